// File: sv/sio_pkg.sv
// shared types, codes and register tables of the super i/o configuration port
package sio_pkg;

  localparam logic       FUNC_WRITE = 1'b1;
  localparam logic       PORT_DATA  = 1'b1;
  localparam logic [7:0] KEY_ENTER  = 8'h55;
  localparam logic [7:0] KEY_EXIT   = 8'hAA;
  localparam logic [7:0] LOW_LIMIT  = 8'h0F;
  localparam logic [7:0] REG_LOCK   = 8'h01;
  localparam logic [7:0] BYTE_FF    = 8'hFF;

  typedef struct packed {
    logic       func;
    logic       data_port;
    logic [7:0] write_data;
  } sio_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       config_mode;
  } sio_rsp_t;

  typedef struct packed {
    logic       we;
    logic [7:0] wdata;
    logic [7:0] sel;
    logic [7:0] sel_next;
  } sio_rf_req_t;

  // bits of the old value that survive a write
  function automatic logic [7:0] keep_bits(input logic [7:0] idx);
    logic [7:0] r;
    case (idx)
      8'h00:   r = 8'h74;
      8'h01:   r = 8'h73;
      8'h02:   r = 8'h77;
      8'h03:   r = 8'h08;
      8'h05:   r = 8'h83;
      8'h07:   r = 8'h06;
      8'h08:   r = 8'h0F;
      8'h09:   r = 8'h38;
      8'h0A:   r = 8'hF0;
      8'h0D:   r = 8'hFF;
      8'h0E:   r = 8'hFF;
      8'h10:   r = 8'h07;
      8'h11:   r = 8'hFC;
      8'h22:   r = 8'h03;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // bits taken from the written byte
  function automatic logic [7:0] take_bits(input logic [7:0] idx);
    logic [7:0] r;
    case (idx)
      8'h00:   r = 8'h8B;
      8'h01:   r = 8'h8C;
      8'h02:   r = 8'h88;
      8'h03:   r = 8'hF7;
      8'h04:   r = 8'hFF;
      8'h05:   r = 8'h7C;
      8'h06:   r = 8'hFF;
      8'h07:   r = 8'hF9;
      8'h08:   r = 8'hF0;
      8'h09:   r = 8'hC7;
      8'h0A:   r = 8'h0F;
      8'h0B,
      8'h0C,
      8'h0F:   r = 8'hFF;
      8'h10:   r = 8'hF8;
      8'h11:   r = 8'h03;
      8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19,
      8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F,
      8'h23, 8'h26, 8'h27, 8'h28: r = 8'hFF;
      8'h20, 8'h21, 8'h22: r = 8'hFC;
      8'h24, 8'h25: r = 8'hFE;
      8'h29:   r = 8'h0F;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // chip defaults
  function automatic logic [7:0] reset_val(input logic [7:0] idx);
    logic [7:0] r;
    case (idx)
      8'h00:   r = 8'h28;
      8'h01:   r = 8'h9C;
      8'h02:   r = 8'h88;
      8'h03:   r = 8'h78;
      8'h06:   r = 8'hFF;
      8'h0D:   r = 8'h03;
      8'h0E:   r = 8'h02;
      8'h1E:   r = 8'h3C;
      8'h20:   r = 8'h3C;
      8'h21:   r = 8'h3C;
      8'h22:   r = 8'h3D;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: sv/superio_config_register_port.sv
// pipeline: 2 register stages, input register then result register; an accepted access beat
// moves into the result register once that is free, and its response is valid from there
// throughput: one access per cycle while rsp_ready does not stall the result register
// reset: synchronous, active high; mode, key, lock and index clear at once,
// the register file reads chip defaults through per-entry valid bits, no clearing pass
module superio_config_register_port #(
  parameter int NUM_REGS = 42
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  sio_pkg::sio_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output sio_pkg::sio_rsp_t rsp
);
  import sio_pkg::*;

  logic        beat_valid, out_free, fire;
  sio_req_t    beat;
  sio_rsp_t    rsp_next;
  sio_rf_req_t rf_req;
  logic [7:0]  cur;

  assign fire = beat_valid && out_free;

  sio_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .fire       (fire),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  sio_ctrl #(.NUM_REGS(NUM_REGS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .beat     (beat),
    .cur      (cur),
    .rsp_next (rsp_next),
    .rf_req   (rf_req)
  );

  sio_regfile #(.NUM_REGS(NUM_REGS)) u_rf (
    .clk    (clk),
    .rst    (rst),
    .rf_req (rf_req),
    .cur    (cur)
  );

  sio_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rsp_next  (rsp_next),
    .out_free  (out_free),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// File: sv/sio_in_reg.sv
// input register for access beats
module sio_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  sio_pkg::sio_req_t req,
  input  logic            fire,
  output logic            beat_valid,
  output sio_pkg::sio_req_t beat
);
  import sio_pkg::*;

  assign req_ready = !beat_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (req_ready) begin
      beat_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      beat <= req;
    end
  end

endmodule

// File: sv/sio_ctrl.sv
// key sequence, index select, lock and read decode
module sio_ctrl #(
  parameter int NUM_REGS = 42
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  sio_pkg::sio_req_t  beat,
  input  logic [7:0]         cur,
  output sio_pkg::sio_rsp_t  rsp_next,
  output sio_pkg::sio_rf_req_t rf_req
);
  import sio_pkg::*;

  localparam logic [7:0] LIMIT = 8'(NUM_REGS);

  logic       unlocked, unlocked_next;
  logic       key_count, key_count_next;
  logic       prot, prot_next;
  logic [7:0] sel, sel_next;
  logic       blocked, present, we;
  logic [7:0] rd;

  always_comb begin
    unlocked_next  = unlocked;
    key_count_next = key_count;
    prot_next      = prot;
    sel_next       = sel;
    we             = 1'b0;
    rd             = 8'h00;
    blocked        = prot && (sel <= LOW_LIMIT);
    present        = sel < LIMIT;
    if (fire) begin
      if (beat.func == FUNC_WRITE) begin
        if (beat.data_port == PORT_DATA) begin
          if (unlocked && !blocked && present) begin
            we = 1'b1;
            if (sel == REG_LOCK) begin
              prot_next = !beat.write_data[7];
            end
          end
        end else if (beat.write_data == KEY_ENTER && !unlocked) begin
          // second key in a row opens the mode
          key_count_next = !key_count;
          if (key_count) begin
            unlocked_next = 1'b1;
          end
        end else if (unlocked) begin
          if (beat.write_data == KEY_EXIT) begin
            unlocked_next = 1'b0;
          end else begin
            sel_next = beat.write_data;
          end
        end else begin
          key_count_next = 1'b0;
        end
      end else begin
        if (!unlocked) begin
          rd = BYTE_FF;
        end else if (beat.data_port != PORT_DATA) begin
          rd = sel;
        end else if (blocked) begin
          rd = BYTE_FF;
        end else if (!present) begin
          rd = 8'h00;
        end else begin
          rd = cur;
        end
      end
    end
  end

  assign rsp_next.read_data   = rd;
  assign rsp_next.config_mode = unlocked_next;

  assign rf_req.we       = we;
  assign rf_req.wdata    = (cur & keep_bits(sel)) | (beat.write_data & take_bits(sel));
  assign rf_req.sel      = sel;
  assign rf_req.sel_next = sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      unlocked  <= 1'b0;
      key_count <= 1'b0;
      prot      <= 1'b0;
      sel       <= 8'h00;
    end else begin
      unlocked  <= unlocked_next;
      key_count <= key_count_next;
      prot      <= prot_next;
      sel       <= sel_next;
    end
  end

endmodule

// File: sv/sio_regfile.sv
// configuration register file with per-entry valid bits and a current-entry register
module sio_regfile #(
  parameter int NUM_REGS = 42
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sio_pkg::sio_rf_req_t rf_req,
  output logic [7:0]           cur
);
  import sio_pkg::*;

  localparam int         AW    = $clog2(NUM_REGS);
  localparam logic [7:0] LIMIT = 8'(NUM_REGS);

  logic [7:0]          mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic                rd_present;

  assign wr_addr    = rf_req.sel[AW-1:0];
  assign rd_addr    = rf_req.sel_next[AW-1:0];
  assign rd_present = rf_req.sel_next < LIMIT;

  always_ff @(posedge clk) begin
    if (rf_req.we) begin
      mem[wr_addr] <= rf_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (rf_req.we) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // cur holds the entry that the selected index points at, or zero for an index past the table
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= reset_val(8'h00);
    end else if (rf_req.we) begin
      cur <= rf_req.wdata;
    end else if (!rd_present) begin
      cur <= 8'h00;
    end else if (valid[rd_addr]) begin
      cur <= mem[rd_addr];
    end else begin
      cur <= reset_val(rf_req.sel_next);
    end
  end

endmodule

// File: sv/sio_out_reg.sv
// result register for response beats
module sio_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  sio_pkg::sio_rsp_t rsp_next,
  output logic              out_free,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output sio_pkg::sio_rsp_t rsp
);
  import sio_pkg::*;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: sv/sio_checker.sv
// port-level assertions for the configuration port, bound to the top level
module sio_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input sio_pkg::sio_rsp_t rsp
);
  import sio_pkg::*;

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  // outside the mode only the fixed read values can come back
  a_closed_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.config_mode |-> (rsp.read_data == BYTE_FF || rsp.read_data == 8'h00))
    else $error("data returned outside configuration mode");

  // pipeline empties on reset and takes a beat straight away
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("pipeline not empty after reset");

  // with the result register empty nothing may hold off the input
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input stalled with result register empty");

endmodule

bind superio_config_register_port sio_checker u_chk (.*);
